// ----- design/v3alu_pkg.sv -----
package v3alu_pkg;

   // Default number format: signed Q16.16.
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Operation codes carried in the request tuser field.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
   localparam logic [OP_W-1:0] OP_SCALE  = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
   localparam logic [OP_W-1:0] OP_DOT    = 4'd4;
   localparam logic [OP_W-1:0] OP_CROSS  = 4'd5;
   localparam logic [OP_W-1:0] OP_SQRMAG = 4'd6;
   localparam logic [OP_W-1:0] OP_MAG    = 4'd7;
   localparam logic [OP_W-1:0] OP_DIST   = 4'd8;
   localparam logic [OP_W-1:0] OP_NORM   = 4'd9;

endpackage

// ----- design/v3alu_sqrt_cell.sv -----
// One step of a restoring square root: consumes two radicand bits and
// produces one root bit per cycle while adv is high, passing the item on to the next cell.
module v3alu_sqrt_cell #(
   parameter int RW     = 33,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              v_in,
   input  logic [2*RW-1:0]   rad_in,
   input  logic [RW-1:0]     root_in,
   input  logic [RW:0]       rem_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              v_ff,
   output logic [2*RW-1:0]   rad_ff,
   output logic [RW-1:0]     root_ff,
   output logic [RW:0]       rem_ff,
   output logic [SIDE_W-1:0] side_ff
);

   logic [RW+2:0] rem_sh;
   logic [RW+2:0] trial;
   logic          take;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      rem_sh = {rem_in, rad_in[2*RW-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // The remainder can reach twice the root, so it keeps RW+1 bits.
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= {rad_in[2*RW-3:0], 2'b00};
         root_ff <= {root_in[RW-2:0], take};
         rem_ff  <= take ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
         side_ff <= side_in;
      end
   end

endmodule

// ----- design/v3alu_div_cell.sv -----
// One step of a restoring divider for three lanes sharing a divisor. The
// numerator register shifts out its top bit and takes in the quotient bit.
module v3alu_div_cell #(
   parameter int NW     = 48,
   parameter int DVW    = 33,
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 v_in,
   input  logic [DVW-1:0]       dvs_in,
   input  logic [2:0][NW-1:0]   num_in,
   input  logic [2:0][DVW-1:0]  rem_in,
   input  logic [SIDE_W-1:0]    side_in,
   output logic                 v_ff,
   output logic [DVW-1:0]       dvs_ff,
   output logic [2:0][NW-1:0]   num_ff,
   output logic [2:0][DVW-1:0]  rem_ff,
   output logic [SIDE_W-1:0]    side_ff
);

   logic [2:0][DVW:0]   rem_sh;
   logic [2:0]          take;
   logic [2:0][NW-1:0]  num_in_n;
   logic [2:0][DVW-1:0] rem_in_n;

   // Compare-and-subtract for each lane.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_sh[i]   = {rem_in[i], num_in[i][NW-1]};
         take[i]     = (rem_sh[i] >= {1'b0, dvs_in});
         rem_in_n[i] = take[i] ? DVW'(rem_sh[i] - {1'b0, dvs_in}) : rem_sh[i][DVW-1:0];
         num_in_n[i] = {num_in[i][NW-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvs_ff  <= dvs_in;
         num_ff  <= num_in_n;
         rem_ff  <= rem_in_n;
         side_ff <= side_in;
      end
   end

endmodule

// ----- design/vector3_fixed_point_alu.sv -----
// Three-component vector unit in signed fixed point (DATA_WIDTH bits, of which
// FRAC_BITS are fractional; Q16.16 by default). It accepts one item per cycle
// while the pipeline is not held, and returns one result item per item, in
// order. Each item passes the input, multiply and sum stage registers, the
// square-root chain of DATA_WIDTH+1 cells, the root stage register, the divider
// chain of DATA_WIDTH+FRAC_BITS cells and the output register, five stage
// registers in all; every operation travels through both chains. Products
// are truncated toward minus infinity, quotients toward zero, and every
// result clips to range and sets the saturated flag. Divide by a zero scalar
// and normalizing a zero vector give a zero vector with div_zero set. Unused
// opcodes give all-zero results. The whole pipeline holds while a result
// waits on rsp_tready.
module vector3_fixed_point_alu
   import v3alu_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (lowest first), zero padded
   input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   // opcode
   input  logic [OP_W-1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // r_x, r_y, r_z, scalar_out (lowest first), zero padded
   output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // div_zero, saturated (lowest first)
   output logic [1:0]                             rsp_tuser
);

   localparam int DW     = DATA_WIDTH;
   localparam int FB     = FRAC_BITS;
   localparam int EW     = DW + 1;
   localparam int PW     = 2 * EW;
   localparam int SUMW   = PW + 2;
   localparam int RW     = DW + 1;
   localparam int SW     = 2 * RW;
   localparam int NW     = DW + FB;
   localparam int DVW    = RW;
   localparam int OUT_W  = ((4*DATA_WIDTH+7)/8)*8;
   localparam int SIDE1W = OP_W + 8*DW + 1;
   localparam int SIDE2W = OP_W + 3 + 1 + 4*DW + 1;

   // Clip a wide signed value to DW bits; returns {clipped, value}.
   function automatic logic [DW:0] sat_fn(input logic signed [SUMW-1:0] v);
      logic signed [SUMW-1:0] hi_lim;
      logic signed [SUMW-1:0] lo_lim;
      hi_lim = {{(SUMW-DW+1){1'b0}}, {(DW-1){1'b1}}};
      lo_lim = {{(SUMW-DW+1){1'b1}}, {(DW-1){1'b0}}};
      if (v > hi_lim) begin
         return {1'b1, 1'b0, {(DW-1){1'b1}}};
      end else if (v < lo_lim) begin
         return {1'b1, 1'b1, {(DW-1){1'b0}}};
      end
      return {1'b0, v[DW-1:0]};
   endfunction

   logic adv;
   logic rsp_valid_ff;

   // The pipeline moves whenever the output register is free or being taken.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------------------------------------------------------------
   // Input stage.
   logic                 va_ff;
   logic [OP_W-1:0]      opa_ff;
   logic [2:0][DW-1:0]   a_in, a_ff, b_in, b_ff;
   logic [DW-1:0]        s_in, s_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = req_tdata[i*DW +: DW];
         b_in[i] = req_tdata[(i+3)*DW +: DW];
      end
      s_in = req_tdata[6*DW +: DW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         opa_ff <= req_tuser;
         a_ff   <= a_in;
         b_ff   <= b_in;
         s_ff   <= s_in;
      end
   end

   // ---------------------------------------------------------------------
   // Multiply stage: six shared multipliers with operands chosen by opcode.
   logic signed [EW-1:0] ae [3];
   logic signed [EW-1:0] be [3];
   logic signed [EW-1:0] de [3];
   logic signed [EW-1:0] se;
   logic signed [EW-1:0] mul_a [6];
   logic signed [EW-1:0] mul_b [6];
   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];
   logic signed [EW-1:0] sumv_in [3];
   logic signed [EW-1:0] sumv_ff [3];
   logic                 vb_ff;
   logic [OP_W-1:0]      opb_ff;
   logic [2:0][DW-1:0]   ab_ff;
   logic [DW-1:0]        sb_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ae[i] = {a_ff[i][DW-1], a_ff[i]};
         be[i] = {b_ff[i][DW-1], b_ff[i]};
         de[i] = ae[i] - be[i];
      end
      se = {s_ff[DW-1], s_ff};
      for (int k = 0; k < 6; k++) begin
         mul_a[k] = '0;
         mul_b[k] = '0;
      end
      unique case (opa_ff) inside
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               mul_a[i] = ae[i];
               mul_b[i] = se;
            end
         end
         OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               mul_a[i] = ae[i];
               mul_b[i] = be[i];
            end
         end
         OP_CROSS: begin
            mul_a[0] = ae[1]; mul_b[0] = be[2];
            mul_a[1] = be[1]; mul_b[1] = ae[2];
            mul_a[2] = be[0]; mul_b[2] = ae[2];
            mul_a[3] = ae[0]; mul_b[3] = be[2];
            mul_a[4] = ae[0]; mul_b[4] = be[1];
            mul_a[5] = be[0]; mul_b[5] = ae[1];
         end
         OP_SQRMAG, OP_MAG, OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               mul_a[i] = ae[i];
               mul_b[i] = ae[i];
            end
         end
         OP_DIST: begin
            for (int i = 0; i < 3; i++) begin
               mul_a[i] = de[i];
               mul_b[i] = de[i];
            end
         end
         default: begin
         end
      endcase
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = mul_a[k] * mul_b[k];
      end
      for (int i = 0; i < 3; i++) begin
         sumv_in[i] = (opa_ff == OP_SUB) ? de[i] : EW'(ae[i] + be[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         sumv_ff <= sumv_in;
         opb_ff  <= opa_ff;
         ab_ff   <= a_ff;
         sb_ff   <= s_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Sum stage: finishes the results that need no root or quotient.
   logic signed [SUMW-1:0] pe [6];
   logic signed [SUMW-1:0] sum3;
   logic signed [SUMW-1:0] wide [3];
   logic [DW:0]            sat_r [3];
   logic [DW:0]            sat_s;
   logic [2:0][DW-1:0]     rvc_in;
   logic [DW-1:0]          soc_in;
   logic                   satc_in;
   logic                   vc_ff;
   logic [SW-1:0]          radc_ff;
   logic [SIDE1W-1:0]      sidec_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         pe[k] = {{(SUMW-PW){prod_ff[k][PW-1]}}, prod_ff[k]};
      end
      sum3 = pe[0] + pe[1] + pe[2];
      for (int i = 0; i < 3; i++) begin
         unique case (opb_ff) inside
            OP_ADD, OP_SUB: wide[i] = {{(SUMW-EW){sumv_ff[i][EW-1]}}, sumv_ff[i]};
            OP_SCALE:       wide[i] = pe[i] >>> FB;
            default:        wide[i] = (pe[2*i] - pe[2*i+1]) >>> FB;
         endcase
         sat_r[i] = sat_fn(wide[i]);
      end
      sat_s   = sat_fn(sum3 >>> FB);
      rvc_in  = '0;
      soc_in  = '0;
      satc_in = 1'b0;
      unique case (opb_ff) inside
         OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               rvc_in[i] = sat_r[i][DW-1:0];
            end
            satc_in = sat_r[0][DW] | sat_r[1][DW] | sat_r[2][DW];
         end
         OP_DOT, OP_SQRMAG: begin
            soc_in  = sat_s[DW-1:0];
            satc_in = sat_s[DW];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         radc_ff  <= sum3[SW-1:0];
         sidec_ff <= {opb_ff, ab_ff, sb_ff, rvc_in, soc_in, satc_in};
      end
   end

   // ---------------------------------------------------------------------
   // Square-root chain: one cell per root bit.
   logic              sq_v    [RW+1];
   logic [SW-1:0]     sq_rad  [RW+1];
   logic [RW-1:0]     sq_root [RW+1];
   logic [RW:0]       sq_rem  [RW+1];
   logic [SIDE1W-1:0] sq_side [RW+1];

   assign sq_v[0]    = vc_ff;
   assign sq_rad[0]  = radc_ff;
   assign sq_root[0] = '0;
   assign sq_rem[0]  = '0;
   assign sq_side[0] = sidec_ff;

   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      v3alu_sqrt_cell #(
         .RW     (RW),
         .SIDE_W (SIDE1W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .v_in    (sq_v[g]),
         .rad_in  (sq_rad[g]),
         .root_in (sq_root[g]),
         .rem_in  (sq_rem[g]),
         .side_in (sq_side[g]),
         .v_ff    (sq_v[g+1]),
         .rad_ff  (sq_rad[g+1]),
         .root_ff (sq_root[g+1]),
         .rem_ff  (sq_rem[g+1]),
         .side_ff (sq_side[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // Root stage: magnitude results and divider set-up.
   logic [OP_W-1:0]    d_op;
   logic [2:0][DW-1:0] d_a;
   logic [DW-1:0]      d_s;
   logic [2:0][DW-1:0] d_rv;
   logic [DW-1:0]      d_so;
   logic               d_sat;
   logic [RW-1:0]      d_root;
   logic [DW:0]        sat_m;
   logic [DW-1:0]      so_d;
   logic               sat_d;
   logic [DVW-1:0]     dvs_d;
   logic               dz_d;
   logic [2:0]         neg_d;
   logic [2:0][NW-1:0] num_d;
   logic [DW-1:0]      mag_a;
   logic [DW-1:0]      mag_s;
   logic               vd_ff;
   logic [DVW-1:0]     dvsd_ff;
   logic [2:0][NW-1:0] numd_ff;
   logic [SIDE2W-1:0]  sided_ff;

   assign {d_op, d_a, d_s, d_rv, d_so, d_sat} = sq_side[RW];
   assign d_root = sq_root[RW];

   always_comb begin
      sat_m = sat_fn({{(SUMW-RW){1'b0}}, d_root});
      so_d  = d_so;
      sat_d = d_sat;
      if (d_op == OP_MAG || d_op == OP_DIST) begin
         so_d  = sat_m[DW-1:0];
         sat_d = sat_m[DW];
      end
      mag_s = d_s[DW-1] ? DW'(~d_s + 1'b1) : d_s;
      dvs_d = {{(DVW-DW){1'b0}}, mag_s};
      dz_d  = 1'b0;
      if (d_op == OP_DIV) begin
         dz_d = (d_s == '0);
      end else if (d_op == OP_NORM) begin
         dvs_d = d_root;
         dz_d  = (d_root == '0);
      end
      for (int i = 0; i < 3; i++) begin
         mag_a    = d_a[i][DW-1] ? DW'(~d_a[i] + 1'b1) : d_a[i];
         num_d[i] = {mag_a, {FB{1'b0}}};
         neg_d[i] = d_a[i][DW-1] ^ ((d_op == OP_DIV) && d_s[DW-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= sq_v[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvsd_ff  <= dvs_d;
         numd_ff  <= num_d;
         sided_ff <= {d_op, neg_d, dz_d, d_rv, so_d, sat_d};
      end
   end

   // ---------------------------------------------------------------------
   // Divider chain: one cell per quotient bit, three lanes each.
   logic                  dv_v    [NW+1];
   logic [DVW-1:0]        dv_dvs  [NW+1];
   logic [2:0][NW-1:0]    dv_num  [NW+1];
   logic [2:0][DVW-1:0]   dv_rem  [NW+1];
   logic [SIDE2W-1:0]     dv_side [NW+1];

   assign dv_v[0]    = vd_ff;
   assign dv_dvs[0]  = dvsd_ff;
   assign dv_num[0]  = numd_ff;
   assign dv_rem[0]  = '0;
   assign dv_side[0] = sided_ff;

   for (genvar g = 0; g < NW; g++) begin : g_div
      v3alu_div_cell #(
         .NW     (NW),
         .DVW    (DVW),
         .SIDE_W (SIDE2W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .v_in    (dv_v[g]),
         .dvs_in  (dv_dvs[g]),
         .num_in  (dv_num[g]),
         .rem_in  (dv_rem[g]),
         .side_in (dv_side[g]),
         .v_ff    (dv_v[g+1]),
         .dvs_ff  (dv_dvs[g+1]),
         .num_ff  (dv_num[g+1]),
         .rem_ff  (dv_rem[g+1]),
         .side_ff (dv_side[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // Quotient stage and output register.
   logic [OP_W-1:0]        e_op;
   logic [2:0]             e_neg;
   logic                   e_dz;
   logic [2:0][DW-1:0]     e_rv;
   logic [DW-1:0]          e_so;
   logic                   e_sat;
   logic signed [SUMW-1:0] qs;
   logic [DW:0]            sat_q;
   logic [2:0][DW-1:0]     rv_e;
   logic                   sat_e;
   logic [OUT_W-1:0]       rsp_data_in, rsp_data_ff;
   logic [1:0]             rsp_user_in, rsp_user_ff;

   assign {e_op, e_neg, e_dz, e_rv, e_so, e_sat} = dv_side[NW];

   always_comb begin
      rv_e  = e_rv;
      sat_e = e_sat;
      for (int i = 0; i < 3; i++) begin
         qs    = {{(SUMW-NW){1'b0}}, dv_num[NW][i]};
         qs    = e_neg[i] ? -qs : qs;
         sat_q = sat_fn(qs);
         if ((e_op == OP_DIV || e_op == OP_NORM) && !e_dz) begin
            rv_e[i] = sat_q[DW-1:0];
            sat_e   = sat_e | sat_q[DW];
         end
      end
      rsp_data_in = '0;
      rsp_data_in[4*DW-1:0] = {e_so, rv_e[2], rv_e[1], rv_e[0]};
      rsp_user_in = {sat_e, e_dz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
